@@ rtl/assert_macros.svh @@
// Assertion macros shared by the lane border tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/lbmt_pkg.sv @@
// Shared constants and types for the lane border midline tracker.
package lbmt_pkg;

  localparam int IMAGE_WIDTH  = 160;
  localparam int IMAGE_HEIGHT = 120;
  localparam int COL_W        = 8;
  localparam int ROW_W        = 7;

  localparam logic [COL_W-1:0] MID_RESET     = COL_W'(80);
  localparam logic [ROW_W-1:0] TOP_ROW_RESET = ROW_W'(72);
  localparam logic [COL_W-1:0] COL_LAST      = COL_W'(IMAGE_WIDTH - 1);
  localparam logic [COL_W-1:0] COL_INNER_MAX = COL_W'(IMAGE_WIDTH - 2);
  localparam logic [COL_W:0]   COL_END       = (COL_W+1)'(IMAGE_WIDTH);
  localparam logic [ROW_W:0]   ROW_END       = (ROW_W+1)'(IMAGE_HEIGHT);

  typedef struct packed {
    logic             edge_pixel;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row_index;
  } pix_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] left_border;
    logic [COL_W-1:0] right_border;
    logic [COL_W-1:0] midline;
  } res_item_t;

  // Read request into the midline store.
  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
  } mid_rd_t;

  // Write request into the midline store.
  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] mid;
  } mid_wr_t;

endpackage

@@ rtl/lbmt_mid_store.sv @@
// Per-row midline memory with reset-value valid bits and write forwarding.
module lbmt_mid_store (
  input  logic                   clk,
  input  logic                   rst,
  input  lbmt_pkg::mid_rd_t      rd,
  input  lbmt_pkg::mid_wr_t      wr,
  output logic [lbmt_pkg::COL_W-1:0] rd_mid
);
  import lbmt_pkg::*;

  logic [COL_W-1:0]        mem [IMAGE_HEIGHT];
  logic [IMAGE_HEIGHT-1:0] written;
  logic [COL_W-1:0]        rd_q;
  logic                    written_q;
  logic                    fwd;
  logic [COL_W-1:0]        fwd_mid;

  // Write the memory array
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row] <= wr.mid;
    end
  end

  // Mark rows that hold a written midline; reset returns all rows to the default
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.row] <= 1'b1;
    end
  end

  // Register read data; hold it while no new read is issued
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_q      <= mem[rd.row];
      written_q <= ({1'b0, rd.row} < ROW_END) && written[rd.row];
      fwd_mid   <= wr.mid;
    end
  end

  // Catch a write to the same row in the read cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd.en) begin
      fwd <= wr.en && (wr.row == rd.row);
    end
  end

  assign rd_mid = fwd ? fwd_mid : (written_q ? rd_q : MID_RESET);

endmodule

@@ rtl/lane_border_midline_tracker_top.sv @@
// Lane border midline tracker: top level with search stage and result register.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------------
//   pixel   | pix_valid | pix_stall | pix  (edge, column, row)
//   result  | res_valid | res_stall | res  (row, left, right, mid)
//   config  | cfg_we    | none      | cfg_data (top_row)
//
// One pixel per cycle unless stalled. Row results are registered after the search stage.
// The midline store read, registered beside the pixel, is the one stage before the result.
// Reset: every stored midline reads as 80 through per-row flags; no clearing pass.
// pix_stall rises only while a row end waits behind a stalled result register.
`include "assert_macros.svh"

module lane_border_midline_tracker_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pix_valid,
  output logic                         pix_stall,
  input  lbmt_pkg::pix_item_t          pix,
  output logic                         res_valid,
  input  logic                         res_stall,
  output lbmt_pkg::res_item_t          res,
  input  logic                         cfg_we,
  input  logic [lbmt_pkg::ROW_W-1:0]   cfg_data
);
  import lbmt_pkg::*;

  logic [ROW_W-1:0] top_row;
  logic             s1_valid;
  pix_item_t        s1_px;
  logic [COL_W-1:0] left_candidate;
  logic [COL_W-1:0] right_candidate;
  logic             right_found;

  logic [COL_W-1:0] mid;
  logic             pix_accept;
  logic             s1_searched;
  logic             s1_emit;
  logic             s1_go;
  logic             row_start;
  logic [COL_W-1:0] left_base;
  logic [COL_W-1:0] right_base;
  logic             found_base;
  logic             hit_left;
  logic             hit_right;
  logic [COL_W-1:0] left_next;
  logic [COL_W-1:0] right_next;
  logic             right_found_next;
  logic [COL_W:0]   border_sum;
  logic [COL_W-1:0] mid_next;
  mid_rd_t          st_rd;
  mid_wr_t          st_wr;
  logic [COL_W:0]   res_sum;
  logic             res_in_window;

  // Midline store
  lbmt_mid_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd     (st_rd),
    .wr     (st_wr),
    .rd_mid (mid)
  );

  // Search stage decisions
  always_comb begin
    s1_searched = (s1_px.row_index > top_row) &&
                  ({1'b0, s1_px.row_index} < ROW_END) &&
                  ({1'b0, s1_px.column} < COL_END);
    s1_emit     = s1_valid && s1_searched && (s1_px.column == COL_LAST);
    s1_go       = !s1_valid || !s1_emit || !res_valid || !res_stall;
    pix_stall   = !s1_go;
    pix_accept  = pix_valid && !pix_stall;

    // Clear candidates at row start, then test this pixel
    row_start  = (s1_px.column == '0);
    left_base  = row_start ? '0 : left_candidate;
    right_base = row_start ? COL_LAST : right_candidate;
    found_base = row_start ? 1'b0 : right_found;

    hit_left  = s1_px.edge_pixel && (s1_px.column != '0) && (s1_px.column <= mid);
    hit_right = s1_px.edge_pixel && !found_base && (s1_px.column >= mid) &&
                (s1_px.column <= COL_INNER_MAX);

    left_next        = hit_left ? s1_px.column : left_base;
    right_next       = hit_right ? s1_px.column : right_base;
    right_found_next = found_base || hit_right;

    border_sum = {1'b0, left_next} + {1'b0, right_next};
    mid_next   = border_sum[COL_W:1];

    st_rd.en  = pix_accept;
    st_rd.row = pix.row_index;
    st_wr.en  = s1_emit && s1_go;
    st_wr.row = s1_px.row_index;
    st_wr.mid = mid_next;

    // Result terms for the checks
    res_sum       = {1'b0, res.left_border} + {1'b0, res.right_border};
    res_in_window = (res.out_row > top_row) && ({1'b0, res.out_row} < ROW_END);
  end

  // Hold the configured top row
  always_ff @(posedge clk) begin
    if (rst) begin
      top_row <= TOP_ROW_RESET;
    end else if (cfg_we) begin
      top_row <= cfg_data;
    end
  end

  // Advance the search stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_go) begin
      s1_valid <= pix_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      s1_px <= pix;
    end
  end

  // Update border candidates as searched pixels leave the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      left_candidate  <= '0;
      right_candidate <= COL_LAST;
      right_found     <= 1'b0;
    end else if (s1_valid && s1_go && s1_searched) begin
      left_candidate  <= left_next;
      right_candidate <= right_next;
      right_found     <= right_found_next;
    end
  end

  // Load the result register at row end; drop it after its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_emit && s1_go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit && s1_go) begin
      res.out_row      <= s1_px.row_index;
      res.left_border  <= left_next;
      res.right_border <= right_next;
      res.midline      <= mid_next;
    end
  end

  // Checks
  `ASSERT_CLK(a_res_mid_avg, res_valid |-> (res_sum[COL_W:1] == res.midline), "bad midline")
  `ASSERT_CLK(a_res_row_searched, res_valid |-> res_in_window, "result outside the window")
  `ASSERT_CLK(a_stage_hold, (s1_valid && pix_stall) |=> (s1_valid && $stable(s1_px)), "pixel lost")
  `ASSERT_NEVER(a_right_inner, right_found && (right_candidate > COL_INNER_MAX), "bad right border")

endmodule

@@ tb/lane_border_midline_tracker_top_tb.sv @@
// Self-checking testbench for the lane border midline tracker top level.
`timescale 1ns / 1ps

module lane_border_midline_tracker_top_tb;
  import lbmt_pkg::*;

  localparam int GAP_PCT     = 27;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 6;

  typedef struct packed {
    pix_item_t p;
    logic      typed;
    logic      want;
    res_item_t r;
  } stim_row_t;

  logic            clk;
  logic            rst;
  logic            pix_valid;
  logic            pix_stall;
  pix_item_t       pix;
  logic            res_valid;
  logic            res_stall;
  res_item_t       res;
  logic            cfg_we;
  logic [ROW_W-1:0] cfg_data;

  // Expectation tags that travel with the pixel being driven
  logic            drv_typed;
  logic            drv_want;
  res_item_t       drv_exp;

  // Predictor state
  logic [COL_W-1:0] mid_mem [0:IMAGE_HEIGHT-1];
  logic [COL_W-1:0] left_cand;
  logic [COL_W-1:0] right_cand;
  logic             right_hit;
  logic [ROW_W-1:0] cur_top;

  res_item_t  pending_borders[$];
  stim_row_t  dir_table[$];

  bit         no_gaps;
  bit         row_hit;
  res_item_t  row_guess;
  res_item_t  got;
  int         n_err;
  int         n_pix;
  int         n_useful;
  int         n_res;
  int         n_cfg;
  int         quiet_cycles;
  int         goal;
  int         tries;
  int         cap;
  int         nt;

  lane_border_midline_tracker_top u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Work out the borders of one accepted pixel; hit is set at a searched row end
  task automatic track_pixel(input pix_item_t p, output bit hit, output res_item_t r);
    logic [COL_W-1:0] mid;
    logic [COL_W:0]   sum;
    hit = 1'b0;
    r   = '0;
    if (p.row_index > cur_top && int'(p.row_index) < IMAGE_HEIGHT &&
        int'(p.column) < IMAGE_WIDTH) begin
      n_useful++;
      // Clear candidates at row start
      if (p.column == '0) begin
        left_cand  = '0;
        right_cand = COL_LAST;
        right_hit  = 1'b0;
      end
      mid = mid_mem[p.row_index];
      if (p.edge_pixel) begin
        if (p.column >= 1 && p.column <= mid)
          left_cand = p.column;
        if (!right_hit && p.column >= mid && p.column <= COL_INNER_MAX) begin
          right_cand = p.column;
          right_hit  = 1'b1;
        end
      end
      // Emit and store the new midline at the last column
      if (p.column == COL_LAST) begin
        sum = {1'b0, left_cand} + {1'b0, right_cand};
        mid_mem[p.row_index] = sum[COL_W:1];
        hit            = 1'b1;
        r.out_row      = p.row_index;
        r.left_border  = left_cand;
        r.right_border = right_cand;
        r.midline      = sum[COL_W:1];
      end
    end
  endtask

  task automatic check_field(input string tag, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want_v, got_v);
      n_err++;
    end
  endtask

  // Track accepted transfers on every channel and compare results
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < IMAGE_HEIGHT; i++)
        mid_mem[i] = MID_RESET;
      left_cand  = '0;
      right_cand = COL_LAST;
      right_hit  = 1'b0;
      cur_top    = TOP_ROW_RESET;
    end else begin
      if (cfg_we) begin
        cur_top = cfg_data;
        n_cfg++;
      end
      if (pix_valid && !pix_stall) begin
        n_pix++;
        track_pixel(pix, row_hit, row_guess);
        if (drv_typed) begin
          if (drv_want)
            pending_borders.push_back(drv_exp);
        end else if (row_hit) begin
          pending_borders.push_back(row_guess);
        end
      end
      if (res_valid && !res_stall) begin
        n_res++;
        if (pending_borders.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual row %0d left %0d right %0d mid %0d",
                   $time, res.out_row, res.left_border, res.right_border, res.midline);
          n_err++;
        end else begin
          got = pending_borders.pop_front();
          check_field("out_row", int'(got.out_row), int'(res.out_row));
          check_field("left_border", int'(got.left_border), int'(res.left_border));
          check_field("right_border", int'(got.right_border), int'(res.right_border));
          check_field("midline", int'(got.midline), int'(res.midline));
        end
      end
    end
  end

  // Stop the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_borders.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    res_stall <= !no_gaps && ($urandom_range(99) < GAP_PCT);
  end

  // Drive one pixel and hold it until the transfer; returns at a falling edge
  task automatic push_pixel(input pix_item_t p, input bit typed, input bit want,
                            input res_item_t exp_r);
    if (!no_gaps) begin
      while ($urandom_range(99) < GAP_PCT) begin
        pix_valid <= 1'b0;
        @(negedge clk);
      end
    end
    pix       <= p;
    drv_typed <= typed;
    drv_want  <= want;
    drv_exp   <= exp_r;
    pix_valid <= 1'b1;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_px(input bit e, input int c, input int r);
    pix_item_t p;
    p.edge_pixel = e;
    p.column     = c[COL_W-1:0];
    p.row_index  = r[ROW_W-1:0];
    push_pixel(p, 1'b0, 1'b0, '0);
  endtask

  task automatic dir_row(input bit e, input int c, input int r, input bit typed,
                         input bit want, input int o_row, input int l, input int rt,
                         input int m);
    stim_row_t s;
    s.p.edge_pixel   = e;
    s.p.column       = c[COL_W-1:0];
    s.p.row_index    = r[ROW_W-1:0];
    s.typed          = typed;
    s.want           = want;
    s.r.out_row      = o_row[ROW_W-1:0];
    s.r.left_border  = l[COL_W-1:0];
    s.r.right_border = rt[COL_W-1:0];
    s.r.midline      = m[COL_W-1:0];
    dir_table.push_back(s);
  endtask

  // Drain, let the pipeline settle, then write top_row
  task automatic retune(input int v);
    pix_valid <= 1'b0;
    while (pending_borders.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v[ROW_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Place one edge just right of the midline: the midline roughly halves each frame down to 1
  task automatic halve_row(input int row);
    int mid;
    mid = int'(mid_mem[row]);
    send_px(mid == 0, 0, row);
    if (mid + 1 <= IMAGE_WIDTH - 2)
      send_px(1'b1, mid + 1, row);
    send_px(1'b0, IMAGE_WIDTH - 1, row);
  endtask

  task automatic send_random_row(input int lo);
    int pick;
    int row;
    int mid;
    int c;
    int prev;
    int n;
    pick = $urandom_range(99);
    if (lo > IMAGE_HEIGHT - 1 || pick < 15) begin
      // Noise over the whole field range
      n = $urandom_range(1, 3);
      repeat (n) send_px(1'($urandom_range(1)), $urandom_range(255), $urandom_range(127));
    end else begin
      if ($urandom_range(99) < 60)
        row = lo + $urandom_range(0, (IMAGE_HEIGHT - 1 - lo < 3) ? IMAGE_HEIGHT - 1 - lo : 3);
      else
        row = $urandom_range(lo, IMAGE_HEIGHT - 1);
      mid = int'(mid_mem[row]);
      if (pick < 25) begin
        // Broken row: missing start, random order, maybe no end
        n = $urandom_range(1, 4);
        repeat (n) send_px(1'($urandom_range(1)), $urandom_range(IMAGE_WIDTH - 1), row);
        if ($urandom_range(1))
          send_px(1'($urandom_range(1)), IMAGE_WIDTH - 1, row);
      end else if (pick < 27) begin
        for (int k = 0; k < IMAGE_WIDTH; k++)
          send_px($urandom_range(99) < 10, k, row);
      end else if (pick < 42) begin
        halve_row(row);
      end else if (pick < 52) begin
        // Left edge just inside the midline and nothing to the right
        send_px(1'b0, 0, row);
        if (mid >= 2)
          send_px(1'b1, mid - 1, row);
        send_px(1'($urandom_range(1)), IMAGE_WIDTH - 1, row);
      end else if (pick < 60) begin
        send_px(1'b0, 0, row);
        send_px(1'($urandom_range(1)), IMAGE_WIDTH - 1, row);
      end else begin
        // Sparse ascending row, sometimes with an edge right on the midline
        send_px(1'($urandom_range(1)), 0, row);
        prev = 0;
        c = $urandom_range(1, 40);
        while (c <= IMAGE_WIDTH - 2) begin
          if (prev < mid && mid < c && $urandom_range(1))
            send_px(1'b1, mid, row);
          send_px(1'($urandom_range(1)), c, row);
          prev = c;
          c += $urandom_range(1, 40);
        end
        send_px(1'($urandom_range(1)), IMAGE_WIDTH - 1, row);
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    pix_valid = 1'b0;
    pix       = '0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    res_stall = 1'b0;
    drv_typed = 1'b0;
    drv_want  = 1'b0;
    drv_exp   = '0;
    no_gaps   = 1'b0;
    n_err     = 0;
    n_pix     = 0;
    n_useful  = 0;
    n_res     = 0;
    n_cfg     = 0;
    quiet_cycles = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows under the reset top_row; all midlines start at 80
    dir_row(0, 159,  73, 1, 1,  73,  0, 159, 79);
    dir_row(1, 159,  72, 1, 0,   0,  0,   0,  0);
    dir_row(1,   5,   0, 1, 0,   0,  0,   0,  0);
    dir_row(1,   0, 119, 0, 0,   0,  0,   0,  0);
    dir_row(1,   1, 119, 0, 0,   0,  0,   0,  0);
    dir_row(1,  80, 119, 0, 0,   0,  0,   0,  0);
    dir_row(1, 158, 119, 0, 0,   0,  0,   0,  0);
    dir_row(1, 159, 119, 1, 1, 119, 80,  80, 80);
    dir_row(1, 200, 119, 1, 0,   0,  0,   0,  0);
    dir_row(1, 159, 120, 1, 0,   0,  0,   0,  0);
    dir_row(1, 159, 127, 1, 0,   0,  0,   0,  0);
    dir_row(0,   0, 100, 0, 0,   0,  0,   0,  0);
    dir_row(1, 158, 100, 0, 0,   0,  0,   0,  0);
    dir_row(0, 159, 100, 1, 1, 100,  0, 158, 79);
    dir_row(1, 255, 100, 1, 0,   0,  0,   0,  0);
    dir_row(1,  10, 100, 0, 0,   0,  0,   0,  0);
    dir_row(1, 159, 100, 0, 0,   0,  0,   0,  0);
    dir_row(0,   0,  73, 0, 0,   0,  0,   0,  0);
    dir_row(1,  79,  73, 0, 0,   0,  0,   0,  0);
    dir_row(0, 159,  73, 0, 0,   0,  0,   0,  0);
    dir_row(0,   0,  74, 0, 0,   0,  0,   0,  0);
    dir_row(1,  50,  74, 0, 0,   0,  0,   0,  0);
    dir_row(0, 159,  74, 0, 0,   0,  0,   0,  0);
    foreach (dir_table[i])
      push_pixel(dir_table[i].p, dir_table[i].typed, dir_table[i].want, dir_table[i].r);

    // Random phases, each under its own top_row
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: nt = 0;
        1: nt = IMAGE_HEIGHT - 1;
        2: nt = IMAGE_HEIGHT - 2;
        3: nt = int'(TOP_ROW_RESET);
        default: nt = $urandom_range(1, IMAGE_HEIGHT - 3);
      endcase
      retune(nt);
      no_gaps = (ph == 4);
      if (ph == 0) begin
        // Walk a few midlines down toward column 1 so both searches get narrow
        repeat (3) begin
          tries = $urandom_range(1, IMAGE_HEIGHT - 1);
          repeat (9) halve_row(tries);
        end
      end
      goal  = n_useful + 170;
      cap   = (nt >= IMAGE_HEIGHT - 1) ? 30 : 400;
      tries = 0;
      while (n_useful < goal && tries < cap) begin
        send_random_row(nt + 1);
        tries++;
      end
    end
    no_gaps = 1'b0;

    // Drain and let the pipeline settle
    pix_valid <= 1'b0;
    while (pending_borders.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d pixel transfers (%0d in searched rows) and %0d row results,",
             n_pix, n_useful, n_res);
    $display("with %0d top_row writes including 0, 118 and 119.", n_cfg);
    if (n_err == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
